// ----- src/tgp_pkg.sv -----
package tgp_pkg;

  // Default edge length of the square bit map, in cells
  localparam int GRID_DEFAULT = 20;

  // Width of the coordinate and distance fields on the ports
  localparam int FIELD_W = 5;

  typedef enum logic [2:0] {
    OP_PEN_UP     = 3'd0,
    OP_PEN_DOWN   = 3'd1,
    OP_TURN_RIGHT = 3'd2,
    OP_TURN_LEFT  = 3'd3,
    OP_MOVE       = 3'd4,
    OP_READ       = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    HD_COL_PLUS  = 2'd0,
    HD_ROW_MINUS = 2'd1,
    HD_COL_MINUS = 2'd2,
    HD_ROW_PLUS  = 2'd3
  } heading_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_DRAIN,
    ST_READ,
    ST_RESP
  } state_t;

endpackage

// ----- src/tgp_map_ram.sv -----
// One row of the bit map per entry; one write port, one registered read port.
module tgp_map_ram #(
  parameter int DEPTH = tgp_pkg::GRID_DEFAULT,
  parameter int WIDTH = tgp_pkg::GRID_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/turtle_grid_plotter.sv -----
// Channel   Handshake               Payload
// cmd       cmd_valid / cmd_ready   opcode, move_distance, read_row, read_col
// rsp       rsp_valid / rsp_ready   status, turtle_row, turtle_col, turtle_heading,
//                                   pen_is_up, cell_value
//
// Sequence: pen, turn, clear, unused op, pen-up, zero-length and rejected move go
// straight to ST_RESP; read cell passes through a read state first; a pen-down move
// steps one cell per cycle through the stepper and the map RAM's single write port.
// Reset: synchronous; map reads as blank, turtle at 0,0 heading 0 with pen up.
// Clear and home takes effect at once through per-row valid flags.
// Stalls: one command in flight; a held result in the output register does not
// stop the next command being taken.
module turtle_grid_plotter #(
  parameter int GRID = tgp_pkg::GRID_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic [2:0] opcode,
  input  logic [4:0] move_distance,
  input  logic [4:0] read_row,
  input  logic [4:0] read_col,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic       status,
  output logic [4:0] turtle_row,
  output logic [4:0] turtle_col,
  output logic [1:0] turtle_heading,
  output logic       pen_is_up,
  output logic       cell_value
);

  // position width (0..GRID), map index width (0..GRID-1), compare width
  localparam int PW = $clog2(GRID + 1);
  localparam int RW = $clog2(GRID);
  localparam int CW = ((PW > tgp_pkg::FIELD_W) ? PW : tgp_pkg::FIELD_W) + 1;
  localparam logic [CW-1:0] GRID_C  = CW'(GRID);
  localparam logic [GRID-1:0] ONE_BIT = GRID'(1);

  tgp_pkg::state_t   state, state_next;
  tgp_pkg::heading_t heading;
  logic [PW-1:0]     pos_row, pos_col;
  logic              pen_up;
  logic [4:0]        steps;
  logic              status_q, cell_q;

  // read-cell request
  logic [RW-1:0]     req_row, req_col;
  logic              req_ok;

  // rows written since the last clear; unwritten rows read as blank
  logic [GRID-1:0]   row_valid;

  // write stage of the draw pipeline, plus last-write bypass
  logic              s1_valid;
  logic [RW-1:0]     s1_row, s1_col;
  logic              fwd_valid;
  logic [RW-1:0]     fwd_row;
  logic [GRID-1:0]   fwd_data;

  logic [GRID-1:0]   rd_data, wr_data, base_row;
  logic [RW-1:0]     rd_addr;

  logic              cmd_fire, rsp_load;
  logic [CW-1:0]     dist_c, prow_c, pcol_c, rr_c, rc_c;
  logic [CW-1:0]     sum_row, dif_row, sum_col, dif_col;
  logic              move_bad, mark_ok;
  logic [PW-1:0]     end_row, end_col, step_row, step_col;

  assign cmd_ready = (state == tgp_pkg::ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;

  assign dist_c = CW'(move_distance);
  assign prow_c = CW'(pos_row);
  assign pcol_c = CW'(pos_col);
  assign rr_c   = CW'(read_row);
  assign rc_c   = CW'(read_col);

  assign sum_row = prow_c + dist_c;
  assign dif_row = prow_c - dist_c;
  assign sum_col = pcol_c + dist_c;
  assign dif_col = pcol_c - dist_c;

  // bounds check and end point of a move
  always_comb begin
    move_bad = (dist_c > GRID_C);
    end_row  = pos_row;
    end_col  = pos_col;
    case (heading)
      tgp_pkg::HD_COL_PLUS: begin
        move_bad = move_bad || (sum_col > GRID_C);
        end_col  = sum_col[PW-1:0];
      end
      tgp_pkg::HD_ROW_MINUS: begin
        move_bad = move_bad || (prow_c < dist_c);
        end_row  = dif_row[PW-1:0];
      end
      tgp_pkg::HD_COL_MINUS: begin
        move_bad = move_bad || (pcol_c < dist_c);
        end_col  = dif_col[PW-1:0];
      end
      default: begin
        move_bad = move_bad || (sum_row > GRID_C);
        end_row  = sum_row[PW-1:0];
      end
    endcase
  end

  // one-cell stepper, reused every cycle of a drawing move
  always_comb begin
    step_row = pos_row;
    step_col = pos_col;
    case (heading)
      tgp_pkg::HD_COL_PLUS:  step_col = pos_col + PW'(1);
      tgp_pkg::HD_ROW_MINUS: step_row = pos_row - PW'(1);
      tgp_pkg::HD_COL_MINUS: step_col = pos_col - PW'(1);
      default:               step_row = pos_row + PW'(1);
    endcase
  end

  // cells on the far edge (coordinate GRID) are never written
  assign mark_ok = (prow_c < GRID_C) && (pcol_c < GRID_C);

  // Map RAM: read issued while stepping (or at read-cell accept), registered
  // data used in the write stage (or the read state). A same-row write in the
  // previous cycle is not yet visible in rd_data, so it is bypassed.
  assign rd_addr  = (state == tgp_pkg::ST_MOVE) ? pos_row[RW-1:0] : rr_c[RW-1:0];
  assign base_row = (fwd_valid && (fwd_row == s1_row)) ? fwd_data :
                    (row_valid[s1_row] ? rd_data : '0);
  assign wr_data  = base_row | (ONE_BIT << s1_col);

  tgp_map_ram #(
    .DEPTH (GRID),
    .WIDTH (GRID)
  ) u_map (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_row),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rsp_load = (state == tgp_pkg::ST_RESP) && (!rsp_valid || rsp_ready);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      tgp_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          case (tgp_pkg::op_t'(opcode))
            tgp_pkg::OP_MOVE: begin
              if (!move_bad && (move_distance != '0) && !pen_up) begin
                state_next = tgp_pkg::ST_MOVE;
              end else begin
                state_next = tgp_pkg::ST_RESP;
              end
            end
            tgp_pkg::OP_READ: state_next = tgp_pkg::ST_READ;
            default:          state_next = tgp_pkg::ST_RESP;
          endcase
        end
      end
      tgp_pkg::ST_MOVE: begin
        if (steps == 5'd1) begin
          state_next = tgp_pkg::ST_DRAIN;
        end
      end
      tgp_pkg::ST_DRAIN: state_next = tgp_pkg::ST_RESP;
      tgp_pkg::ST_READ:  state_next = tgp_pkg::ST_RESP;
      tgp_pkg::ST_RESP: begin
        if (rsp_load) begin
          state_next = tgp_pkg::ST_IDLE;
        end
      end
      default: state_next = tgp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // turtle state and map bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_row   <= '0;
      pos_col   <= '0;
      heading   <= tgp_pkg::HD_COL_PLUS;
      pen_up    <= 1'b1;
      row_valid <= '0;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= (state == tgp_pkg::ST_MOVE) && mark_ok;
      fwd_valid <= s1_valid;
      if (s1_valid) begin
        row_valid[s1_row] <= 1'b1;
      end
      if (state == tgp_pkg::ST_MOVE) begin
        pos_row <= step_row;
        pos_col <= step_col;
      end
      if (cmd_fire) begin
        case (tgp_pkg::op_t'(opcode))
          tgp_pkg::OP_PEN_UP:     pen_up  <= 1'b1;
          tgp_pkg::OP_PEN_DOWN:   pen_up  <= 1'b0;
          tgp_pkg::OP_TURN_RIGHT: heading <= tgp_pkg::heading_t'(heading - 2'd1);
          tgp_pkg::OP_TURN_LEFT:  heading <= tgp_pkg::heading_t'(heading + 2'd1);
          tgp_pkg::OP_MOVE: begin
            // pen up: jump straight to the end point
            if (!move_bad && pen_up) begin
              pos_row <= end_row;
              pos_col <= end_col;
            end
          end
          tgp_pkg::OP_CLEAR: begin
            pos_row   <= '0;
            pos_col   <= '0;
            heading   <= tgp_pkg::HD_COL_PLUS;
            row_valid <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_row   <= pos_row[RW-1:0];
    s1_col   <= pos_col[RW-1:0];
    fwd_row  <= s1_row;
    fwd_data <= wr_data;
    if (state == tgp_pkg::ST_MOVE) begin
      steps <= steps - 5'd1;
    end
    if (cmd_fire) begin
      status_q <= (tgp_pkg::op_t'(opcode) == tgp_pkg::OP_MOVE) && move_bad;
      cell_q   <= 1'b0;
      steps    <= move_distance;
      req_row  <= rr_c[RW-1:0];
      req_col  <= rc_c[RW-1:0];
      req_ok   <= (rr_c < GRID_C) && (rc_c < GRID_C);
    end
    if (state == tgp_pkg::ST_READ) begin
      cell_q <= req_ok && row_valid[req_row] && rd_data[req_col];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      status         <= status_q;
      turtle_row     <= prow_c[4:0];
      turtle_col     <= pcol_c[4:0];
      turtle_heading <= heading;
      pen_is_up      <= pen_up;
      cell_value     <= cell_q;
    end
  end

  // turtle never leaves 0..GRID
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (prow_c <= GRID_C) && (pcol_c <= GRID_C))
    else $error("turtle position beyond grid edge");

  // stepping always has a cell left to do
  a_steps_live: assert property (@(posedge clk) disable iff (rst)
    (state == tgp_pkg::ST_MOVE) |-> (steps != '0))
    else $error("stepping with zero cells left");

  // map writes stay inside the map
  a_write_in_map: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (CW'(s1_row) < GRID_C) && (CW'(s1_col) < GRID_C))
    else $error("map write outside the grid");

  // no map write is pending once the result is being formed
  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (state == tgp_pkg::ST_RESP) |-> !s1_valid)
    else $error("map write still pending at result");

endmodule

// ----- tb/turtle_grid_plotter_checker.sv -----
module turtle_grid_plotter_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic       cmd_ready,
  input  logic [2:0] opcode,
  input  logic [4:0] move_distance,
  input  logic [4:0] read_row,
  input  logic [4:0] read_col,
  input  logic       rsp_valid,
  input  logic       rsp_ready,
  input  logic       status,
  input  logic [4:0] turtle_row,
  input  logic [4:0] turtle_col,
  input  logic [1:0] turtle_heading,
  input  logic       pen_is_up,
  input  logic       cell_value,
  output int         fail_count,
  output int         pending,
  output int         results_seen,
  output int         refused_moves,
  output int         inked_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID = tgp_pkg::GRID_DEFAULT;

  typedef struct packed {
    logic       status;
    logic [4:0] row;
    logic [4:0] col;
    logic [1:0] hd;
    logic       pen_up;
    logic       cell_bit;
  } plot_result_t;

  plot_result_t awaited_results[$];

  // shadow turtle
  logic [GRID-1:0]   ink [GRID];
  int                row_pos;
  int                col_pos;
  tgp_pkg::heading_t hd;
  logic              pen_up;

  task automatic home_turtle();
    foreach (ink[r]) ink[r] = '0;
    row_pos = 0;
    col_pos = 0;
    hd = tgp_pkg::HD_COL_PLUS;
  endtask

  task automatic plot_command(input logic [2:0] op, input logic [4:0] move_len,
                              input logic [4:0] rr, input logic [4:0] rc,
                              output plot_result_t res);
    int   steps;
    int   dr;
    int   dc;
    logic refused;
    steps = move_len;
    dr = 0;
    dc = 0;
    refused = 1'b0;
    res = '0;
    case (op)
      tgp_pkg::OP_PEN_UP:     pen_up = 1'b1;
      tgp_pkg::OP_PEN_DOWN:   pen_up = 1'b0;
      tgp_pkg::OP_TURN_RIGHT: hd = tgp_pkg::heading_t'(hd + 2'd3);
      tgp_pkg::OP_TURN_LEFT:  hd = tgp_pkg::heading_t'(hd + 2'd1);
      tgp_pkg::OP_MOVE: begin
        if (steps > GRID) begin
          refused = 1'b1;
        end else begin
          case (hd)
            tgp_pkg::HD_COL_PLUS:
              if (col_pos + steps > GRID) refused = 1'b1; else dc = 1;
            tgp_pkg::HD_ROW_MINUS:
              if (row_pos < steps) refused = 1'b1; else dr = -1;
            tgp_pkg::HD_COL_MINUS:
              if (col_pos < steps) refused = 1'b1; else dc = -1;
            default:
              if (row_pos + steps > GRID) refused = 1'b1; else dr = 1;
          endcase
        end
        if (!refused) begin
          // ink every cell left behind; the far edge at GRID holds no cells
          for (int i = 0; i < steps; i++) begin
            if (!pen_up && row_pos < GRID && col_pos < GRID) ink[row_pos][col_pos] = 1'b1;
            row_pos += dr;
            col_pos += dc;
          end
        end
      end
      tgp_pkg::OP_READ:  if (rr < GRID && rc < GRID) res.cell_bit = ink[rr][rc];
      tgp_pkg::OP_CLEAR: home_turtle();
      default: ;
    endcase
    res.status = refused;
    res.row    = row_pos[4:0];
    res.col    = col_pos[4:0];
    res.hd     = hd;
    res.pen_up = pen_up;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    plot_result_t want;
    plot_result_t got;
    if (rst) begin
      home_turtle();
      pen_up = 1'b1;
      awaited_results.delete();
    end else begin
      // result first: it belongs to an older transaction than any command taken now
      if (rsp_valid && rsp_ready) begin
        got = {status, turtle_row, turtle_col, turtle_heading, pen_is_up, cell_value};
        results_seen++;
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, got);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("turtle_row", want.row, got.row);
          check_field("turtle_col", want.col, got.col);
          check_field("turtle_heading", want.hd, got.hd);
          check_field("pen_is_up", want.pen_up, got.pen_up);
          check_field("cell_value", want.cell_bit, got.cell_bit);
          if (want.status) refused_moves++;
          if (want.cell_bit) inked_reads++;
        end
      end
      if (cmd_valid && cmd_ready) begin
        plot_command(opcode, move_distance, read_row, read_col, want);
        awaited_results.push_back(want);
      end
    end
    pending <= awaited_results.size();
  end

endmodule

// ----- tb/turtle_grid_plotter_tb.sv -----
module turtle_grid_plotter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID = tgp_pkg::GRID_DEFAULT;
  // opcode 7 has no meaning; the block must report the state untouched
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_ready;
  logic [2:0] opcode = tgp_pkg::OP_PEN_UP;
  logic [4:0] move_distance = '0;
  logic [4:0] read_row = '0;
  logic [4:0] read_col = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  logic       status;
  logic [4:0] turtle_row;
  logic [4:0] turtle_col;
  logic [1:0] turtle_heading;
  logic       pen_is_up;
  logic       cell_value;

  int fail_count;
  int pending;
  int results_seen;
  int refused_moves;
  int inked_reads;

  // idling odds, in percent per cycle
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int cmd_count = 0;

  // long hold-off of the result side: the stimulus bumps hold_reqs,
  // the receiver process does the counting
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  turtle_grid_plotter dut (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .opcode         (opcode),
    .move_distance  (move_distance),
    .read_row       (read_row),
    .read_col       (read_col),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .status         (status),
    .turtle_row     (turtle_row),
    .turtle_col     (turtle_col),
    .turtle_heading (turtle_heading),
    .pen_is_up      (pen_is_up),
    .cell_value     (cell_value)
  );

  turtle_grid_plotter_checker plot_check (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .opcode         (opcode),
    .move_distance  (move_distance),
    .read_row       (read_row),
    .read_col       (read_col),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .status         (status),
    .turtle_row     (turtle_row),
    .turtle_col     (turtle_col),
    .turtle_heading (turtle_heading),
    .pen_is_up      (pen_is_up),
    .cell_value     (cell_value),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .refused_moves  (refused_moves),
    .inked_reads    (inked_reads)
  );

  // Result side: either serving a long hold-off or stalling at the phase's odds
  always @(posedge clk) begin
    if (hold_reqs != hold_served) begin
      hold_served <= hold_reqs;
      hold_left   <= 300;
      rsp_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // One command transaction. Idle cycles come first, so valid is only ever
  // dropped after an accepted transaction and never toggled within a step.
  task automatic send_cmd(input logic [2:0] op, input logic [4:0] move_len,
                          input logic [4:0] rr, input logic [4:0] rc);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid     <= 1'b1;
    opcode        <= op;
    move_distance <= move_len;
    read_row      <= rr;
    read_col      <= rc;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    cmd_count++;
  endtask

  // Mostly short moves with the pen down, so the turtle wanders the whole map,
  // runs into every edge and leaves plenty of ink for reads to find.
  // Clears are rare so the map fills up between them.
  task automatic send_random_cmd();
    int         pick;
    logic [2:0] op;
    logic [4:0] move_len;
    logic [4:0] rr;
    logic [4:0] rc;
    pick = $urandom_range(99);
    if (pick < 40)      op = tgp_pkg::OP_MOVE;
    else if (pick < 50) op = tgp_pkg::OP_TURN_RIGHT;
    else if (pick < 60) op = tgp_pkg::OP_TURN_LEFT;
    else if (pick < 68) op = tgp_pkg::OP_PEN_DOWN;
    else if (pick < 72) op = tgp_pkg::OP_PEN_UP;
    else if (pick < 96) op = tgp_pkg::OP_READ;
    else if (pick < 98) op = tgp_pkg::OP_CLEAR;
    else                op = OP_UNUSED;
    pick = $urandom_range(99);
    if (pick < 70)      move_len = 5'($urandom_range(8));
    else if (pick < 90) move_len = 5'($urandom_range(GRID));
    else                move_len = 5'($urandom_range(31));
    // reads mostly land on the map, the rest range over the whole 5-bit field
    rr = ($urandom_range(3) != 0) ? 5'($urandom_range(GRID - 1)) : 5'($urandom_range(31));
    rc = ($urandom_range(3) != 0) ? 5'($urandom_range(GRID - 1)) : 5'($urandom_range(31));
    send_cmd(op, move_len, rr, rc);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct = idle_pct;
    rsp_stall_pct <= stall_pct;
    repeat (count) send_random_cmd();
  endtask

  initial begin
    int waited;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: trace the border of the map, then poke a corner and cells off the map
    send_cmd(tgp_pkg::OP_READ, 5'd0, 5'd0, 5'd0);        // blank map after reset
    send_cmd(tgp_pkg::OP_MOVE, 5'd0, 5'd0, 5'd0);        // zero distance
    send_cmd(tgp_pkg::OP_MOVE, 5'd21, 5'd0, 5'd0);       // distance beyond the grid
    send_cmd(tgp_pkg::OP_TURN_LEFT, 5'd0, 5'd0, 5'd0);
    send_cmd(tgp_pkg::OP_MOVE, 5'd1, 5'd0, 5'd0);        // would go above row 0
    send_cmd(tgp_pkg::OP_TURN_LEFT, 5'd0, 5'd0, 5'd0);
    send_cmd(tgp_pkg::OP_MOVE, 5'd1, 5'd0, 5'd0);        // would go left of column 0
    send_cmd(tgp_pkg::OP_TURN_LEFT, 5'd0, 5'd0, 5'd0);
    send_cmd(tgp_pkg::OP_PEN_DOWN, 5'd0, 5'd0, 5'd0);
    send_cmd(tgp_pkg::OP_MOVE, 5'd20, 5'd0, 5'd0);       // full column down to row GRID
    send_cmd(tgp_pkg::OP_TURN_LEFT, 5'd0, 5'd0, 5'd0);   // heading wraps 3 to 0
    send_cmd(tgp_pkg::OP_MOVE, 5'd20, 5'd0, 5'd0);       // along row GRID, nothing inked
    send_cmd(tgp_pkg::OP_MOVE, 5'd1, 5'd0, 5'd0);        // past column GRID
    send_cmd(tgp_pkg::OP_TURN_LEFT, 5'd0, 5'd0, 5'd0);
    send_cmd(tgp_pkg::OP_MOVE, 5'd20, 5'd0, 5'd0);       // up column GRID, nothing inked
    send_cmd(tgp_pkg::OP_TURN_LEFT, 5'd0, 5'd0, 5'd0);
    send_cmd(tgp_pkg::OP_MOVE, 5'd20, 5'd0, 5'd0);       // back along row 0
    send_cmd(tgp_pkg::OP_READ, 5'd31, 5'd0, 5'd19);
    send_cmd(tgp_pkg::OP_READ, 5'd0, 5'd20, 5'd0);       // just off the map
    send_cmd(tgp_pkg::OP_READ, 5'd0, 5'd31, 5'd31);
    send_cmd(OP_UNUSED, 5'd31, 5'd31, 5'd31);
    send_cmd(tgp_pkg::OP_TURN_RIGHT, 5'd0, 5'd0, 5'd0);
    send_cmd(tgp_pkg::OP_TURN_RIGHT, 5'd0, 5'd0, 5'd0);
    send_cmd(tgp_pkg::OP_TURN_RIGHT, 5'd0, 5'd0, 5'd0);  // heading wraps 0 to 3
    send_cmd(tgp_pkg::OP_PEN_UP, 5'd0, 5'd0, 5'd0);
    send_cmd(tgp_pkg::OP_MOVE, 5'd5, 5'd0, 5'd0);        // jump without ink
    send_cmd(tgp_pkg::OP_CLEAR, 5'd0, 5'd0, 5'd0);       // pen stays up

    // Random phases, one per idling pattern
    run_phase(0, 0, 300);

    // Back-pressure: hold the result side off while commands keep coming,
    // so the output register fills and the command side stalls
    hold_reqs <= hold_reqs + 1;
    run_phase(0, 0, 40);

    run_phase(83, 0, 320);
    run_phase(0, 83, 320);
    run_phase(38, 38, 320);

    cmd_valid <= 1'b0;
    rsp_stall_pct <= 0;

    // drain, then allow for the longest pen-down move
    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d commands, checked %0d results: %0d moves refused, %0d reads hit ink.",
             cmd_count, results_seen, refused_moves, inked_reads);
    $display("Idling covered: none, sender only, receiver only, both, and a long hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("turtle_grid_plotter_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending);
      $display("turtle_grid_plotter_tb: FAIL");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", pending);
    $display("turtle_grid_plotter_tb: FAIL");
    $finish;
  end

endmodule
